>>> sv/bmrm_pkg.sv
// shared types and constants for the byte memory register machine core
package bmrm_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_F1,
    S_F2,
    S_F3,
    S_F4,
    S_R1,
    S_EX,
    S_LD,
    S_RD,
    S_DONE
  } state_t;

  // item operations
  localparam logic [1:0] OPN_WRITE   = 2'd0;
  localparam logic [1:0] OPN_READ    = 2'd1;
  localparam logic [1:0] OPN_RESTART = 2'd2;
  localparam logic [1:0] OPN_EXEC    = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_MEM = 2'd1;
  localparam logic [1:0] STAT_REG = 2'd2;

  // instruction opcodes
  localparam logic [31:0] OPC_MOV  = 32'd0;
  localparam logic [31:0] OPC_ADD  = 32'd1;
  localparam logic [31:0] OPC_MUL  = 32'd2;
  localparam logic [31:0] OPC_JMP  = 32'd3;
  localparam logic [31:0] OPC_LOAD = 32'd4;
  localparam logic [31:0] OPC_STOR = 32'd5;
  localparam logic [31:0] OPC_HALT = 32'd6;

  // pc step of one instruction
  localparam logic [31:0] INSN_STEP = 32'd16;

  // word write request into the byte store
  typedef struct packed {
    logic        en;
    logic [31:0] addr;
    logic [31:0] data;
  } wr_req_t;

endpackage

>>> sv/byte_memory_register_machine_core_top.sv
// top level: item sequencer of the register machine core
// After reset a clearing pass zeroes both memories while no item is accepted.
// Then one item is worked at a time. An instruction takes four fetch reads
// from the byte store port, which returns one word per cycle, two register
// file reads, the execute step and, for a load, one data read. The result
// waits in an output register, so the next item is taken while it is still
// stalled.
module byte_memory_register_machine_core_top #(
  parameter int MEM_BYTES = 4096,
  parameter int NUM_REGS  = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [11:0]        address,
  input  logic signed [31:0] data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_data,
  output logic signed [31:0] program_counter,
  output logic               halted,
  output logic signed [31:0] halt_value,
  output logic [1:0]         status
);

  localparam int ROWS  = MEM_BYTES / 4;
  localparam int RW    = $clog2(ROWS);
  localparam int RIW   = $clog2(NUM_REGS);
  localparam int CLR_N = (ROWS > NUM_REGS) ? ROWS : NUM_REGS;
  localparam int CNW   = $clog2(CLR_N + 1);

  bmrm_pkg::state_t state, state_next;

  logic [CNW-1:0] cnt, cnt_next;
  logic [31:0]    pc, pc_next;
  logic           stopped, stopped_next;
  logic [31:0]    hv, hv_next;
  logic [31:0]    op, op_next;
  logic [31:0]    imm, imm_next;
  logic [31:0]    r1, r1_next;
  logic [31:0]    r2, r2_next;
  logic [31:0]    rv1, rv1_next;
  logic [31:0]    res_rdata, res_rdata_next;
  logic [1:0]     res_st, res_st_next;
  logic           out_valid_next;
  logic           out_load;

  bmrm_pkg::wr_req_t bm_wr;
  logic              bm_clr_en;
  logic [RW-1:0]     bm_clr_row;
  logic              bm_rd_en;
  logic signed [33:0] bm_rd_addr;
  logic [31:0]       bm_rd_data;

  logic              rf_wr_en;
  logic [RIW-1:0]    rf_wr_idx;
  logic [31:0]       rf_wr_data;
  logic              rf_rd_en;
  logic [31:0]       rf_rd_idx;
  logic [31:0]       rf_rd_data;

  logic signed [33:0] pc_s;
  logic [31:0]        rv2;
  logic               r2z;
  logic               r2p;
  logic               r1_ok;
  logic               rv2_word_ok;
  logic               io_word_ok;
  logic               do_wr;
  logic [31:0]        wr_val;
  logic               jump;

  bmrm_bytemem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk     (clk),
    .clr_en  (bm_clr_en),
    .clr_row (bm_clr_row),
    .wr      (bm_wr),
    .rd_en   (bm_rd_en),
    .rd_addr (bm_rd_addr),
    .rd_data (bm_rd_data)
  );

  bmrm_regfile #(.NUM_REGS(NUM_REGS)) u_rf (
    .clk     (clk),
    .wr_en   (rf_wr_en),
    .wr_idx  (rf_wr_idx),
    .wr_data (rf_wr_data),
    .rd_en   (rf_rd_en),
    .rd_idx  (rf_rd_idx),
    .rd_data (rf_rd_data)
  );

  // decode helpers
  assign pc_s        = {{2{pc[31]}}, pc};
  assign rv2         = rf_rd_data;
  assign r2z         = (r2 == 32'd0);
  assign r2p         = !r2[31] && !r2z;
  assign r1_ok       = !r1[31] && (r1 < 32'(NUM_REGS));
  assign rv2_word_ok = !rv2[31] && (rv2 <= 32'(MEM_BYTES - 4));
  assign io_word_ok  = ({20'b0, address} <= 32'(MEM_BYTES - 4));
  assign out_load    = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bmrm_pkg::S_CLEAR: begin
        if (cnt == CNW'(CLR_N - 1)) state_next = bmrm_pkg::S_IDLE;
      end
      bmrm_pkg::S_IDLE: begin
        if (in_valid) begin
          case (operation)
            bmrm_pkg::OPN_READ: state_next = bmrm_pkg::S_RD;
            bmrm_pkg::OPN_EXEC: state_next = stopped ? bmrm_pkg::S_DONE : bmrm_pkg::S_F1;
            default:            state_next = bmrm_pkg::S_DONE;
          endcase
        end
      end
      bmrm_pkg::S_F1: state_next = bmrm_pkg::S_F2;
      bmrm_pkg::S_F2: state_next = bmrm_pkg::S_F3;
      bmrm_pkg::S_F3: state_next = bmrm_pkg::S_F4;
      bmrm_pkg::S_F4: state_next = bmrm_pkg::S_R1;
      bmrm_pkg::S_R1: state_next = bmrm_pkg::S_EX;
      bmrm_pkg::S_EX: begin
        state_next = (op == bmrm_pkg::OPC_LOAD && r2p) ? bmrm_pkg::S_LD : bmrm_pkg::S_DONE;
      end
      bmrm_pkg::S_LD: state_next = bmrm_pkg::S_DONE;
      bmrm_pkg::S_RD: state_next = bmrm_pkg::S_DONE;
      bmrm_pkg::S_DONE: begin
        if (out_load) state_next = bmrm_pkg::S_IDLE;
      end
      default: state_next = bmrm_pkg::S_IDLE;
    endcase
  end

  // memory requests and register updates
  always_comb begin
    in_stall       = 1'b1;
    cnt_next       = cnt;
    pc_next        = pc;
    stopped_next   = stopped;
    hv_next        = hv;
    op_next        = op;
    imm_next       = imm;
    r1_next        = r1;
    r2_next        = r2;
    rv1_next       = rv1;
    res_rdata_next = res_rdata;
    res_st_next    = res_st;
    out_valid_next = out_valid && out_stall;
    bm_wr          = '0;
    bm_clr_en      = 1'b0;
    bm_clr_row     = cnt[RW-1:0];
    bm_rd_en       = 1'b0;
    bm_rd_addr     = pc_s;
    rf_wr_en       = 1'b0;
    rf_wr_idx      = r1[RIW-1:0];
    rf_wr_data     = 32'd0;
    rf_rd_en       = 1'b0;
    rf_rd_idx      = r1;
    do_wr          = 1'b0;
    wr_val         = 32'd0;
    jump           = 1'b0;
    case (state)
      bmrm_pkg::S_CLEAR: begin
        cnt_next   = cnt + CNW'(1);
        bm_clr_en  = (cnt < CNW'(ROWS));
        rf_wr_en   = (cnt < CNW'(NUM_REGS));
        rf_wr_idx  = cnt[RIW-1:0];
      end
      bmrm_pkg::S_IDLE: begin
        in_stall       = 1'b0;
        res_rdata_next = 32'd0;
        res_st_next    = bmrm_pkg::STAT_OK;
        if (in_valid) begin
          case (operation)
            bmrm_pkg::OPN_WRITE: begin
              if (io_word_ok) begin
                bm_wr = '{en: 1'b1, addr: {20'b0, address}, data: data};
              end else begin
                res_st_next = bmrm_pkg::STAT_MEM;
              end
            end
            bmrm_pkg::OPN_READ: begin
              bm_rd_en   = 1'b1;
              bm_rd_addr = {22'b0, address};
            end
            bmrm_pkg::OPN_RESTART: begin
              pc_next      = 32'd0;
              stopped_next = 1'b0;
              hv_next      = 32'd0;
            end
            default: begin
              bm_rd_en = !stopped;
            end
          endcase
        end
      end
      // instruction fetch, one word per cycle
      bmrm_pkg::S_F1: begin
        op_next    = bm_rd_data;
        bm_rd_en   = 1'b1;
        bm_rd_addr = pc_s + 34'sd4;
      end
      bmrm_pkg::S_F2: begin
        imm_next   = bm_rd_data;
        bm_rd_en   = 1'b1;
        bm_rd_addr = pc_s + 34'sd8;
      end
      bmrm_pkg::S_F3: begin
        r1_next    = bm_rd_data;
        bm_rd_en   = 1'b1;
        bm_rd_addr = pc_s + 34'sd12;
      end
      bmrm_pkg::S_F4: begin
        r2_next   = bm_rd_data;
        rf_rd_en  = 1'b1;
        rf_rd_idx = r1;
      end
      bmrm_pkg::S_R1: begin
        rv1_next  = rf_rd_data;
        rf_rd_en  = 1'b1;
        rf_rd_idx = r2;
      end
      // execute with both register values at hand
      bmrm_pkg::S_EX: begin
        case (op)
          bmrm_pkg::OPC_MOV: begin
            do_wr  = r2z || r2p;
            wr_val = r2z ? imm : rv2;
          end
          bmrm_pkg::OPC_ADD: begin
            do_wr  = r2z || r2p;
            wr_val = rv1 + (r2z ? imm : rv2);
          end
          bmrm_pkg::OPC_MUL: begin
            do_wr  = r2p;
            wr_val = 32'(rv1 * rv2);
          end
          bmrm_pkg::OPC_JMP: begin
            jump = r2z || (r2p && rv2 != 32'd0);
          end
          bmrm_pkg::OPC_LOAD: begin
            bm_rd_en   = r2p;
            bm_rd_addr = {{2{rv2[31]}}, rv2};
          end
          bmrm_pkg::OPC_STOR: begin
            if (r2p) begin
              if (rv2_word_ok) begin
                bm_wr = '{en: 1'b1, addr: rv2, data: rv1};
              end else begin
                res_st_next = bmrm_pkg::STAT_MEM;
              end
            end
          end
          bmrm_pkg::OPC_HALT: begin
            if (r2z || (r2p && rv2 != 32'd0)) begin
              stopped_next = 1'b1;
              hv_next      = rv1;
            end
          end
          default: begin
          end
        endcase
        pc_next = jump ? rv1 : pc + bmrm_pkg::INSN_STEP;
        if (do_wr) begin
          if (r1_ok) begin
            rf_wr_en   = 1'b1;
            rf_wr_data = wr_val;
          end else begin
            res_st_next = bmrm_pkg::STAT_REG;
          end
        end
      end
      bmrm_pkg::S_LD: begin
        if (r1_ok) begin
          rf_wr_en   = 1'b1;
          rf_wr_data = bm_rd_data;
        end else begin
          res_st_next = bmrm_pkg::STAT_REG;
        end
      end
      bmrm_pkg::S_RD: begin
        res_rdata_next = bm_rd_data;
      end
      bmrm_pkg::S_DONE: begin
        if (out_load) out_valid_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmrm_pkg::S_CLEAR;
      cnt       <= '0;
      pc        <= 32'd0;
      stopped   <= 1'b0;
      hv        <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pc        <= pc_next;
      stopped   <= stopped_next;
      hv        <= hv_next;
      out_valid <= out_valid_next;
    end
  end

  // instruction words and result payload
  always_ff @(posedge clk) begin
    op        <= op_next;
    imm       <= imm_next;
    r1        <= r1_next;
    r2        <= r2_next;
    rv1       <= rv1_next;
    res_rdata <= res_rdata_next;
    res_st    <= res_st_next;
    if (state == bmrm_pkg::S_DONE && out_load) begin
      read_data       <= res_rdata;
      program_counter <= pc;
      halted          <= stopped;
      halt_value      <= hv;
      status          <= res_st;
    end
  end

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == bmrm_pkg::S_DONE)
    else $error("result item raised outside the done state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state != bmrm_pkg::S_IDLE)
    else $error("accepted item did not start work");

  a_store_write_state: assert property (@(posedge clk) disable iff (rst)
    bm_wr.en |-> (state == bmrm_pkg::S_IDLE || state == bmrm_pkg::S_EX))
    else $error("byte store written outside an access step");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == bmrm_pkg::STAT_OK || status == bmrm_pkg::STAT_MEM ||
                   status == bmrm_pkg::STAT_REG))
    else $error("result status is not a known code");

  a_no_clear_with_write: assert property (@(posedge clk) disable iff (rst)
    bm_clr_en |-> !bm_wr.en && in_stall)
    else $error("clearing pass overlaps a store write or an accept");
`endif

endmodule

>>> sv/bmrm_bytemem.sv
// byte store in four interleaved banks, one big-endian word per cycle
module bmrm_bytemem #(
  parameter int MEM_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 clr_en,
  input  logic [$clog2(MEM_BYTES/4)-1:0] clr_row,
  input  bmrm_pkg::wr_req_t    wr,
  input  logic                 rd_en,
  input  logic signed [33:0]   rd_addr,
  output logic [31:0]          rd_data
);

  localparam int ROWS = MEM_BYTES / 4;
  localparam int RW   = $clog2(ROWS);

  wire  [3:0][7:0] bank_q;
  logic [3:0][33:0] rbyte;
  logic [3:0]      rvld;
  logic [3:0]      vld_q;
  logic [1:0]      alo_q;

  // byte-in-range flags of the word being read
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rbyte[k] = rd_addr + 34'(k);
      rvld[k]  = !rbyte[k][33] && (rbyte[k] < 34'(MEM_BYTES));
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_q <= rvld;
      alo_q <= rd_addr[1:0];
    end
  end

  // one bank per byte lane of the address
  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [7:0]    q;
    logic [1:0]    kw;
    logic [1:0]    kr;
    logic [33:0]   wb;
    logic [33:0]   rb;
    logic [7:0]    wbyte;
    logic [RW-1:0] wrow;
    logic [RW-1:0] rrow;

    assign kw    = 2'(j) - wr.addr[1:0];
    assign wb    = {2'b00, wr.addr} + {32'b0, kw};
    assign wrow  = wb[RW+1:2];
    assign wbyte = 8'(wr.data >> {(2'd3 - kw), 3'b000});
    assign kr    = 2'(j) - rd_addr[1:0];
    assign rb    = rd_addr + {32'b0, kr};
    assign rrow  = rb[RW+1:2];

    always_ff @(posedge clk) begin
      if (clr_en) begin
        mem[clr_row] <= 8'd0;
      end else if (wr.en) begin
        mem[wrow] <= wbyte;
      end
      if (rd_en) begin
        q <= mem[rrow];
      end
    end

    assign bank_q[j] = q;
  end

  // reassemble the word, bytes outside the store read as zero
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_data[31-8*k -: 8] = vld_q[k] ? bank_q[alo_q + 2'(k)] : 8'd0;
    end
  end

endmodule

>>> sv/bmrm_regfile.sv
// register file memory, one read and one write port
module bmrm_regfile #(
  parameter int NUM_REGS = 256
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(NUM_REGS)-1:0] wr_idx,
  input  logic [31:0]                 wr_data,
  input  logic                        rd_en,
  input  logic [31:0]                 rd_idx,
  output logic [31:0]                 rd_data
);

  localparam int RIW = $clog2(NUM_REGS);

  logic [31:0] regs [NUM_REGS];
  logic [31:0] q;
  logic        v;

  // write and registered read, out of range index reads zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      regs[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      q <= regs[rd_idx[RIW-1:0]];
      v <= !rd_idx[31] && (rd_idx < 32'(NUM_REGS));
    end
  end

  assign rd_data = v ? q : 32'd0;

endmodule

>>> dv/byte_memory_register_machine_core_top_tb.sv
// testbench for the byte memory register machine core: table-driven and random items
module byte_memory_register_machine_core_top_tb;

  localparam int MEM_SZ   = 4096;
  localparam int REG_CNT  = 256;
  localparam int N_RANDOM = 1250;
  localparam int N_QUIET  = 150;

  typedef struct packed {
    logic [31:0] rdata;
    logic [31:0] pcv;
    logic        hlt;
    logic [31:0] hval;
    logic [1:0]  st;
  } machine_out_t;

  typedef struct packed {
    logic [1:0]   op;
    logic [11:0]  addr;
    logic [31:0]  data;
    logic         typed;
    machine_out_t exp;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         operation;
  logic [11:0]        address;
  logic signed [31:0] data;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] read_data;
  logic signed [31:0] program_counter;
  logic               halted;
  logic signed [31:0] halt_value;
  logic [1:0]         status;

  // shadow machine state
  logic [7:0]   mem_bytes [MEM_SZ];
  logic [31:0]  regs [REG_CNT];
  logic [31:0]  pc_q;
  logic         stop_q;
  logic [31:0]  halt_q;

  machine_out_t pending_q [$];
  int           errors;
  int           sent;
  int           n_exec;
  int           n_halts;
  int           n_bad_st;
  bit           quiet;
  plan_row_t    plan [23];

  byte_memory_register_machine_core_top dut (.*);

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // big-endian word read, bytes outside memory are zero
  function automatic logic [31:0] word_at(longint a);
    logic [31:0] v;
    longint b;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      b = a + k;
      v = {v[23:0], (b >= 0 && b < MEM_SZ) ? mem_bytes[b] : 8'h00};
    end
    return v;
  endfunction

  function automatic logic [1:0] store_word(longint a, logic [31:0] v);
    if (a < 0 || a + 3 >= MEM_SZ) return bmrm_pkg::STAT_MEM;
    for (int k = 0; k < 4; k++) mem_bytes[a + k] = v[31 - 8 * k -: 8];
    return bmrm_pkg::STAT_OK;
  endfunction

  function automatic logic [31:0] reg_val(int i);
    return (i >= 0 && i < REG_CNT) ? regs[i] : 32'd0;
  endfunction

  function automatic logic [1:0] set_reg(int i, logic [31:0] v);
    if (i < 0 || i >= REG_CNT) return bmrm_pkg::STAT_REG;
    regs[i] = v;
    return bmrm_pkg::STAT_OK;
  endfunction

  // one instruction at pc
  function automatic logic [1:0] run_insn();
    longint      p;
    logic [31:0] opc;
    logic [31:0] imm;
    int          r1;
    int          r2;
    logic        jump;
    logic [1:0]  st;
    p    = longint'($signed(pc_q));
    opc  = word_at(p);
    imm  = word_at(p + 4);
    r1   = $signed(word_at(p + 8));
    r2   = $signed(word_at(p + 12));
    jump = 1'b0;
    st   = bmrm_pkg::STAT_OK;
    case (opc)
      bmrm_pkg::OPC_MOV: begin
        if (r2 == 0) st = set_reg(r1, imm);
        else if (r2 >= 1) st = set_reg(r1, reg_val(r2));
      end
      bmrm_pkg::OPC_ADD: begin
        if (r2 == 0) st = set_reg(r1, reg_val(r1) + imm);
        else if (r2 >= 1) st = set_reg(r1, reg_val(r1) + reg_val(r2));
      end
      bmrm_pkg::OPC_MUL: begin
        if (r2 >= 1) st = set_reg(r1, reg_val(r1) * reg_val(r2));
      end
      bmrm_pkg::OPC_JMP: begin
        if (r2 == 0 || (r2 >= 1 && reg_val(r2) != 0)) jump = 1'b1;
      end
      bmrm_pkg::OPC_LOAD: begin
        if (r2 >= 1) st = set_reg(r1, word_at(longint'($signed(reg_val(r2)))));
      end
      bmrm_pkg::OPC_STOR: begin
        if (r2 >= 1) st = store_word(longint'($signed(reg_val(r2))), reg_val(r1));
      end
      bmrm_pkg::OPC_HALT: begin
        if (r2 == 0 || (r2 >= 1 && reg_val(r2) != 0)) begin
          stop_q = 1'b1;
          halt_q = reg_val(r1);
          n_halts++;
        end
      end
      default: ;
    endcase
    pc_q = jump ? reg_val(r1) : pc_q + bmrm_pkg::INSN_STEP;
    return st;
  endfunction

  // predicted result of one item, updates the shadow state
  function automatic machine_out_t machine_step(logic [1:0] op, logic [11:0] a,
                                                logic [31:0] d);
    machine_out_t r;
    r.rdata = '0;
    r.st    = bmrm_pkg::STAT_OK;
    case (op)
      bmrm_pkg::OPN_WRITE: r.st = store_word(longint'(a), d);
      bmrm_pkg::OPN_READ:  r.rdata = word_at(longint'(a));
      bmrm_pkg::OPN_RESTART: begin
        pc_q   = '0;
        stop_q = 1'b0;
        halt_q = '0;
      end
      default: begin
        n_exec++;
        if (!stop_q) r.st = run_insn();
      end
    endcase
    r.pcv  = pc_q;
    r.hlt  = stop_q;
    r.hval = stop_q ? halt_q : 32'd0;
    return r;
  endfunction

  // offer one item and wait until it is taken
  task automatic send_item(logic [1:0] op, logic [11:0] a, logic [31:0] d,
                           logic typed, machine_out_t exp);
    machine_out_t r;
    in_valid  <= 1'b1;
    operation <= op;
    address   <= a;
    data      <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = machine_step(op, a, d);
    if (r.st != bmrm_pkg::STAT_OK) n_bad_st++;
    pending_q.push_back(typed ? exp : r);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // random instruction words, biased toward small register indexes and addresses
  function automatic logic [31:0] rand_opcode();
    if ($urandom_range(0, 99) < 88) return 32'($urandom_range(0, 6));
    return ($urandom_range(0, 1) == 0) ? 32'($urandom_range(7, 20)) : 32'($urandom);
  endfunction

  function automatic logic [31:0] rand_imm();
    int c;
    c = $urandom_range(0, 99);
    if (c < 40) return 32'($urandom_range(0, MEM_SZ - 1));
    if (c < 60) return 32'(16 * $urandom_range(0, 8));
    if (c < 65) return 32'hFFFF_FFF0;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_reg_idx(bit second);
    int c;
    c = $urandom_range(0, 99);
    if (second && c < 35) return 32'd0;
    if (c < 85) return 32'($urandom_range(0, 7));
    if (c < 93) return 32'($urandom_range(REG_CNT - 6, REG_CNT + 4));
    return $urandom | 32'h8000_0000;
  endfunction

  // receiver: random stall bursts and one long hold-off
  initial begin
    bit long_done;
    long_done = 1'b0;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!long_done && sent >= 600) begin
        long_done = 1'b1;
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    machine_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (read_data !== e.rdata) begin
          $error("read_data expected %h got %h", e.rdata, read_data);
          errors++;
        end
        if (program_counter !== e.pcv) begin
          $error("program_counter expected %h got %h", e.pcv, program_counter);
          errors++;
        end
        if (halted !== e.hlt) begin
          $error("halted expected %b got %b", e.hlt, halted);
          errors++;
        end
        if (halt_value !== e.hval) begin
          $error("halt_value expected %h got %h", e.hval, halt_value);
          errors++;
        end
        if (status !== e.st) begin
          $error("status expected %0d got %0d", e.st, status);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // stimulus
  initial begin
    machine_out_t none;
    int           n_ins;
    int           n_run;
    int           base;
    none   = '0;
    errors = 0;
    sent   = 0;
    n_exec = 0;
    n_halts = 0;
    n_bad_st = 0;
    quiet  = 1'b0;
    for (int i = 0; i < MEM_SZ; i++) mem_bytes[i] = '0;
    for (int i = 0; i < REG_CNT; i++) regs[i] = '0;
    pc_q   = '0;
    stop_q = 1'b0;
    halt_q = '0;
    in_valid  <= 1'b0;
    operation <= bmrm_pkg::OPN_WRITE;
    address   <= '0;
    data      <= '0;
    rst       <= 1'b1;

    // directed: extremes of the store, halt, halted exec, restart, bad register,
    // negative reg2, jump, unknown opcode
    plan = '{
      '{bmrm_pkg::OPN_READ,    12'd0,    32'd0,          1'b1,
        '{32'd0, 32'd0, 1'b0, 32'd0, bmrm_pkg::STAT_OK}},
      '{bmrm_pkg::OPN_WRITE,   12'd4095, 32'hFFFF_FFFF,  1'b1,
        '{32'd0, 32'd0, 1'b0, 32'd0, bmrm_pkg::STAT_MEM}},
      '{bmrm_pkg::OPN_WRITE,   12'd4092, 32'h8000_0000,  1'b0, none},
      '{bmrm_pkg::OPN_READ,    12'd4092, 32'd0,          1'b1,
        '{32'h8000_0000, 32'd0, 1'b0, 32'd0, bmrm_pkg::STAT_OK}},
      '{bmrm_pkg::OPN_READ,    12'd4094, 32'd0,          1'b0, none},
      '{bmrm_pkg::OPN_EXEC,    12'd0,    32'd0,          1'b1,
        '{32'd0, 32'd16, 1'b0, 32'd0, bmrm_pkg::STAT_OK}},
      '{bmrm_pkg::OPN_WRITE,   12'd16,   bmrm_pkg::OPC_HALT, 1'b0, none},
      '{bmrm_pkg::OPN_WRITE,   12'd24,   32'd5,          1'b0, none},
      '{bmrm_pkg::OPN_EXEC,    12'd0,    32'd0,          1'b1,
        '{32'd0, 32'd32, 1'b1, 32'd0, bmrm_pkg::STAT_OK}},
      '{bmrm_pkg::OPN_EXEC,    12'd0,    32'd0,          1'b1,
        '{32'd0, 32'd32, 1'b1, 32'd0, bmrm_pkg::STAT_OK}},
      '{bmrm_pkg::OPN_RESTART, 12'd0,    32'd0,          1'b1,
        '{32'd0, 32'd0, 1'b0, 32'd0, bmrm_pkg::STAT_OK}},
      '{bmrm_pkg::OPN_WRITE,   12'd8,    32'd300,        1'b0, none},
      '{bmrm_pkg::OPN_WRITE,   12'd4,    32'd123,        1'b0, none},
      '{bmrm_pkg::OPN_EXEC,    12'd0,    32'd0,          1'b1,
        '{32'd0, 32'd16, 1'b0, 32'd0, bmrm_pkg::STAT_REG}},
      '{bmrm_pkg::OPN_WRITE,   12'd12,   32'hFFFF_FFFF,  1'b0, none},
      '{bmrm_pkg::OPN_RESTART, 12'd0,    32'd0,          1'b0, none},
      '{bmrm_pkg::OPN_EXEC,    12'd0,    32'd0,          1'b1,
        '{32'd0, 32'd16, 1'b0, 32'd0, bmrm_pkg::STAT_OK}},
      '{bmrm_pkg::OPN_WRITE,   12'd0,    bmrm_pkg::OPC_JMP, 1'b0, none},
      '{bmrm_pkg::OPN_WRITE,   12'd12,   32'd0,          1'b0, none},
      '{bmrm_pkg::OPN_RESTART, 12'd0,    32'd0,          1'b0, none},
      '{bmrm_pkg::OPN_EXEC,    12'd0,    32'd0,          1'b1,
        '{32'd0, 32'd0, 1'b0, 32'd0, bmrm_pkg::STAT_OK}},
      '{bmrm_pkg::OPN_WRITE,   12'd0,    32'd99,         1'b0, none},
      '{bmrm_pkg::OPN_EXEC,    12'd0,    32'd0,          1'b0, none}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i])
      send_item(plan[i].op, plan[i].addr, plan[i].data, plan[i].typed, plan[i].exp);

    // random: short programs written at a base, then executed, with noise between
    while (sent < N_RANDOM + 23) begin
      if (sent > N_RANDOM + 23 - N_QUIET) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0: send_item(bmrm_pkg::OPN_READ, 12'($urandom), 32'($urandom), 1'b0, none);
        1: send_item(bmrm_pkg::OPN_WRITE, 12'($urandom_range(MEM_SZ - 8, MEM_SZ - 1)),
                     32'($urandom), 1'b0, none);
        2: send_item(bmrm_pkg::OPN_WRITE, 12'($urandom), 32'($urandom), 1'b0, none);
        default: begin
          if ($urandom_range(0, 1) == 0) send_item(bmrm_pkg::OPN_RESTART, 12'($urandom),
                                                    32'($urandom), 1'b0, none);
          base  = ($urandom_range(0, 3) == 0) ? 16 * $urandom_range(0, 8) : 0;
          n_ins = $urandom_range(1, 8);
          for (int k = 0; k < n_ins; k++) begin
            send_item(bmrm_pkg::OPN_WRITE, 12'(base + 16 * k), rand_opcode(), 1'b0, none);
            send_item(bmrm_pkg::OPN_WRITE, 12'(base + 16 * k + 4), rand_imm(), 1'b0, none);
            send_item(bmrm_pkg::OPN_WRITE, 12'(base + 16 * k + 8), rand_reg_idx(1'b0),
                      1'b0, none);
            send_item(bmrm_pkg::OPN_WRITE, 12'(base + 16 * k + 12), rand_reg_idx(1'b1),
                      1'b0, none);
          end
          n_run = $urandom_range(1, 12);
          for (int k = 0; k < n_run; k++)
            send_item(bmrm_pkg::OPN_EXEC, 12'($urandom), 32'($urandom), 1'b0, none);
        end
      endcase
    end
    in_valid <= 1'b0;

    // drain
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d items, %0d executes, %0d halts taken, %0d non-ok status",
             sent, n_exec, n_halts, n_bad_st);
    $display("including a 200 cycle output hold-off with the input backed up");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bmrm_pkg.sv
sv/bmrm_bytemem.sv
sv/bmrm_regfile.sv
sv/byte_memory_register_machine_core_top.sv
dv/byte_memory_register_machine_core_top_tb.sv
